/* src/stsr_pkg.sv */
`default_nettype none

package stsr_pkg;

  // Defaults for the table capacities
  localparam int unsigned MAX_ROWS_DEF = 1024;
  localparam int unsigned MAX_COLS_DEF = 1024;

  // Index and dense-number width, fixed by the 11-bit coordinate fields
  localparam int unsigned IDX_W = 11;
  localparam int unsigned IDX_SPAN = 2 ** IDX_W;

  localparam int unsigned VAL_W = 64;

  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned OUT_DEPTH = 4;

  // Function codes of an input word
  localparam logic [1:0] FUNC_LOAD_ROW = 2'd0;
  localparam logic [1:0] FUNC_LOAD_COL = 2'd1;
  localparam logic [1:0] FUNC_ENTRY    = 2'd2;
  localparam logic [1:0] FUNC_START    = 2'd3;

  typedef enum logic [1:0] {
    CMD_WR_ROW = 2'd0,
    CMD_WR_COL = 2'd1,
    CMD_ENTRY  = 2'd2
  } cmd_op_e;

  typedef struct packed {
    logic             keep;
    logic [IDX_W-1:0] num;
  } tbl_entry_t;

  typedef struct packed {
    cmd_op_e          op;
    logic             row_ok;
    logic             col_ok;
    logic [IDX_W-1:0] row_addr;
    logic [IDX_W-1:0] col_addr;
    tbl_entry_t       wdata;
    logic [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic             kept;
    logic [IDX_W-1:0] new_row;
    logic [IDX_W-1:0] new_col;
    logic [VAL_W-1:0] value;
    logic             index_error;
  } result_t;

endpackage

`default_nettype wire

/* src/stsr_fifo.sv */
`default_nettype none

module stsr_fifo #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire T                           wdata_i,
  input  wire logic                       pop_i,
  output T                                rdata_o,
  output logic                            full_o,
  output logic                            empty_o,
  output logic [$clog2(DEPTH+1)-1:0]      count_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  T                mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;
  logic            do_push, do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

/* src/stsr_front.sv */
`default_nettype none

module stsr_front
  import stsr_pkg::*;
#(
  parameter int unsigned MAX_ROWS = MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = MAX_COLS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic             cmd_full_i,
  input  wire logic [1:0]       func_i,
  input  wire logic             mask_bit_i,
  input  wire logic [IDX_W-1:0] row_index_i,
  input  wire logic [IDX_W-1:0] col_index_i,
  input  wire logic [VAL_W-1:0] entry_value_i,
  output logic                  cmd_push_o,
  output cmd_t                  cmd_o
);

  localparam int unsigned RLW = $clog2(MAX_ROWS + 1);
  localparam int unsigned CLW = $clog2(MAX_COLS + 1);
  localparam int unsigned RCW = (RLW > IDX_W) ? RLW : IDX_W;
  localparam int unsigned CCW = (CLW > IDX_W) ? CLW : IDX_W;
  // Positions past the coordinate range are never read back: keep no storage for them
  localparam int unsigned ROW_DEPTH = (MAX_ROWS < IDX_SPAN) ? MAX_ROWS : IDX_SPAN;
  localparam int unsigned COL_DEPTH = (MAX_COLS < IDX_SPAN) ? MAX_COLS : IDX_SPAN;

  logic [RLW-1:0]   rows_loaded_q, rows_loaded_d;
  logic [CLW-1:0]   cols_loaded_q, cols_loaded_d;
  logic [IDX_W-1:0] rows_kept_q, rows_kept_d;
  logic [IDX_W-1:0] cols_kept_q, cols_kept_d;
  logic             accept;
  logic             row_room, col_room;
  logic             row_ok, col_ok;

  assign accept   = push_i && !cmd_full_i;
  assign row_room = rows_loaded_q < RLW'(MAX_ROWS);
  assign col_room = cols_loaded_q < CLW'(MAX_COLS);
  assign row_ok   = (row_index_i != '0) && (RCW'(row_index_i) <= RCW'(rows_loaded_q));
  assign col_ok   = (col_index_i != '0) && (CCW'(col_index_i) <= CCW'(cols_loaded_q));

  always_comb begin
    rows_loaded_d  = rows_loaded_q;
    cols_loaded_d  = cols_loaded_q;
    rows_kept_d    = rows_kept_q;
    cols_kept_d    = cols_kept_q;
    cmd_push_o     = 1'b0;
    cmd_o.op       = CMD_ENTRY;
    cmd_o.row_ok   = row_ok;
    cmd_o.col_ok   = col_ok;
    cmd_o.row_addr = row_index_i - IDX_W'(1);
    cmd_o.col_addr = col_index_i - IDX_W'(1);
    cmd_o.wdata    = '0;
    cmd_o.value    = entry_value_i;
    case (func_i)
      FUNC_LOAD_ROW: begin
        cmd_o.op       = CMD_WR_ROW;
        cmd_o.row_addr = IDX_W'(rows_loaded_q);
        cmd_o.wdata.keep = mask_bit_i;
        if (mask_bit_i) begin
          cmd_o.wdata.num = rows_kept_q + IDX_W'(1);
        end
        if (accept && row_room) begin
          rows_loaded_d = rows_loaded_q + RLW'(1);
          if (mask_bit_i) begin
            rows_kept_d = rows_kept_q + IDX_W'(1);
          end
          cmd_push_o = RCW'(rows_loaded_q) < RCW'(ROW_DEPTH);
        end
      end
      FUNC_LOAD_COL: begin
        cmd_o.op       = CMD_WR_COL;
        cmd_o.col_addr = IDX_W'(cols_loaded_q);
        cmd_o.wdata.keep = mask_bit_i;
        if (mask_bit_i) begin
          cmd_o.wdata.num = cols_kept_q + IDX_W'(1);
        end
        if (accept && col_room) begin
          cols_loaded_d = cols_loaded_q + CLW'(1);
          if (mask_bit_i) begin
            cols_kept_d = cols_kept_q + IDX_W'(1);
          end
          cmd_push_o = CCW'(cols_loaded_q) < CCW'(COL_DEPTH);
        end
      end
      FUNC_ENTRY: begin
        cmd_push_o = accept;
      end
      FUNC_START: begin
        if (accept) begin
          rows_loaded_d = '0;
          cols_loaded_d = '0;
          rows_kept_d   = '0;
          cols_kept_d   = '0;
        end
      end
      default: begin
        cmd_push_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_loaded_q <= '0;
      cols_loaded_q <= '0;
      rows_kept_q   <= '0;
      cols_kept_q   <= '0;
    end else begin
      rows_loaded_q <= rows_loaded_d;
      cols_loaded_q <= cols_loaded_d;
      rows_kept_q   <= rows_kept_d;
      cols_kept_q   <= cols_kept_d;
    end
  end

endmodule

`default_nettype wire

/* src/stsr_back.sv */
`default_nettype none

module stsr_back
  import stsr_pkg::*;
#(
  parameter int unsigned MAX_ROWS = MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = MAX_COLS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cmd_empty_i,
  input  wire cmd_t                           cmd_i,
  output logic                                cmd_pop_o,
  input  wire logic [$clog2(OUT_DEPTH+1)-1:0] out_count_i,
  output logic                                res_push_o,
  output result_t                             res_o
);

  localparam int unsigned ROW_DEPTH = (MAX_ROWS < IDX_SPAN) ? MAX_ROWS : IDX_SPAN;
  localparam int unsigned COL_DEPTH = (MAX_COLS < IDX_SPAN) ? MAX_COLS : IDX_SPAN;
  localparam int unsigned RAW = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
  localparam int unsigned CAW = (COL_DEPTH > 1) ? $clog2(COL_DEPTH) : 1;
  localparam int unsigned OCW = $clog2(OUT_DEPTH + 1);

  tbl_entry_t       row_mem [ROW_DEPTH];
  tbl_entry_t       col_mem [COL_DEPTH];
  tbl_entry_t       row_rd_q, col_rd_q;
  logic             s1_valid_q;
  logic             s1_row_ok_q, s1_col_ok_q;
  logic [VAL_W-1:0] s1_value_q;
  logic             is_entry, room, issue;
  logic             both_ok;

  assign is_entry = (cmd_i.op == CMD_ENTRY);
  // Count the read in flight so the result queue never overflows
  assign room     = (OCW'(out_count_i) + OCW'(s1_valid_q)) < OCW'(OUT_DEPTH);
  assign cmd_pop_o = !cmd_empty_i && (!is_entry || room);
  assign issue    = cmd_pop_o && is_entry;

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && (cmd_i.op == CMD_WR_ROW)) begin
      row_mem[cmd_i.row_addr[RAW-1:0]] <= cmd_i.wdata;
    end
    if (issue && cmd_i.row_ok) begin
      row_rd_q <= row_mem[cmd_i.row_addr[RAW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && (cmd_i.op == CMD_WR_COL)) begin
      col_mem[cmd_i.col_addr[CAW-1:0]] <= cmd_i.wdata;
    end
    if (issue && cmd_i.col_ok) begin
      col_rd_q <= col_mem[cmd_i.col_addr[CAW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_row_ok_q <= cmd_i.row_ok;
      s1_col_ok_q <= cmd_i.col_ok;
      s1_value_q  <= cmd_i.value;
    end
  end

  assign both_ok    = s1_row_ok_q && s1_col_ok_q;
  assign res_push_o = s1_valid_q;

  always_comb begin
    res_o.kept        = both_ok && row_rd_q.keep && col_rd_q.keep;
    res_o.new_row     = res_o.kept ? row_rd_q.num : '0;
    res_o.new_col     = res_o.kept ? col_rd_q.num : '0;
    res_o.value       = s1_value_q;
    res_o.index_error = !both_ok;
  end

endmodule

`default_nettype wire

/* src/sparse_triplet_subset_renumber_unit.sv */
`default_nettype none

// Sparse triplet row/column subset and renumbering. Words enter through a queue
// interface (push/full) with a 2-bit function: load a row mask bit, load a column
// mask bit, an entry, or start. Start clears the load counters; mask bits are then
// loaded in position order and every kept position gets the next dense 1-based
// number, while loads past MAX_ROWS or MAX_COLS are ignored. Each entry word
// carries a 1-based row, column and a 64-bit value and yields exactly one result
// word (empty/pop): kept, the renumbered row and column (zero unless kept), the
// value unchanged, and index_error when either index is zero or past the loaded
// positions. Loads and start yield no result. Rate: one word per cycle sustained
// while the result queue has room, set by the single write or paired read per
// cycle of the renumbering tables; an entry's result passes the command queue,
// the registered table read and the result queue before it is visible. The tables
// need no clearing pass after reset, so words are accepted right out of reset.
module sparse_triplet_subset_renumber_unit
  import stsr_pkg::*;
#(
  parameter int unsigned MAX_ROWS = MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = MAX_COLS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // input word queue
  input  wire logic             push,
  output logic                  full,
  input  wire logic [1:0]       func_i,
  input  wire logic             mask_bit_i,
  input  wire logic [IDX_W-1:0] row_index_i,
  input  wire logic [IDX_W-1:0] col_index_i,
  input  wire logic [VAL_W-1:0] entry_value_i,
  // result word queue
  output logic                  empty,
  input  wire logic             pop,
  output logic                  kept_o,
  output logic [IDX_W-1:0]      new_row_o,
  output logic [IDX_W-1:0]      new_col_o,
  output logic [VAL_W-1:0]      value_out_o,
  output logic                  index_error_o
);

  cmd_t                            front_cmd, back_cmd;
  logic                            front_cmd_push;
  logic                            cmd_empty, cmd_pop;
  result_t                         back_res, head_res;
  logic                            back_res_push;
  logic [$clog2(OUT_DEPTH+1)-1:0]  out_count;

  // Front: track load counters, range-check entries, emit table commands
  stsr_front #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .cmd_full_i    (full),
    .func_i        (func_i),
    .mask_bit_i    (mask_bit_i),
    .row_index_i   (row_index_i),
    .col_index_i   (col_index_i),
    .entry_value_i (entry_value_i),
    .cmd_push_o    (front_cmd_push),
    .cmd_o         (front_cmd)
  );

  // Hold commands in order so table writes land before later reads
  stsr_fifo #(
    .T     (cmd_t),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_cmd_push),
    .wdata_i (front_cmd),
    .pop_i   (cmd_pop),
    .rdata_o (back_cmd),
    .full_o  (full),
    .empty_o (cmd_empty),
    .count_o ()
  );

  // Back: write and read the renumbering tables, assemble results
  stsr_back #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (back_cmd),
    .cmd_pop_o   (cmd_pop),
    .out_count_i (out_count),
    .res_push_o  (back_res_push),
    .res_o       (back_res)
  );

  // Result queue decouples the back end from a stalled consumer
  stsr_fifo #(
    .T     (result_t),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (back_res_push),
    .wdata_i (back_res),
    .pop_i   (pop),
    .rdata_o (head_res),
    .full_o  (),
    .empty_o (empty),
    .count_o (out_count)
  );

  assign kept_o        = head_res.kept;
  assign new_row_o     = head_res.new_row;
  assign new_col_o     = head_res.new_col;
  assign value_out_o   = head_res.value;
  assign index_error_o = head_res.index_error;

endmodule

`default_nettype wire
